@@ design/velocity_verlet_step_top_assert.svh @@
// Assertion macros used by the velocity Verlet step top level.
`ifndef VELOCITY_VERLET_STEP_TOP_ASSERT_SVH
`define VELOCITY_VERLET_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define VVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define VVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/vvs_pkg.sv @@
// Shared types, constants and helper functions of the velocity Verlet step.
`timescale 1ns / 1ps

package vvs_pkg;

	// Fixed-point format and register defaults.
	localparam int FRAC_BITS = 16;
	localparam int DT_W = 31;
	localparam logic [DT_W-1:0] TIME_STEP_RST = 31'd655;
	localparam int QUEUE_DEPTH = 4;

	// One restoring step per quotient bit.
	localparam int DIV_STEPS = 32;

	// Drift datapath widths.
	localparam int WMAG_W = 62 - FRAC_BITS;
	localparam int WHI_W = WMAG_W - 32;
	localparam int PHI_W = WHI_W + DT_W;
	localparam int SUM_W = WMAG_W + DT_W + 1;
	localparam int RES_W = 41;
	localparam logic [RES_W-1:0] BIG_CAP = 41'h100_0000_0000;

	typedef enum logic {
		REQ_DRIFT = 1'b0,
		REQ_KICK  = 1'b1
	} req_t;

	// Classified item as it sits in the queue.
	typedef struct packed {
		req_t               kind;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic               force_neg;
		logic [31:0]        force_mag;
		logic [30:0]        mass;
		logic               mass_zero;
	} entry_t;

	// Queue status seen by both neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Item as it travels through the back-end pipeline.
	typedef struct packed {
		req_t               kind;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic               force_neg;
		logic [30:0]        mass;
		logic               mass_zero;
		logic               sat;
		logic               ovf;
		logic [30:0]        rem;
		logic [31:0]        dq;
		logic               neg;
		logic [62:0]        scr_a;
		logic [PHI_W-1:0]   scr_b;
	} pipe_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} sat_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r.sat = 1'b1;
			r.val = 32'sh7fff_ffff;
		end else if (v < 64'shffff_ffff_8000_0000) begin
			r.sat = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = $signed(v[31:0]);
		end
		return r;
	endfunction

	// One restoring division step: shift in a dividend bit, retire a quotient bit.
	function automatic pipe_t div_step(input pipe_t p);
		pipe_t       r;
		logic [31:0] r2;
		logic        ge;
		r = p;
		r2 = {p.rem, p.dq[31]};
		ge = (r2 >= {1'b0, p.mass});
		r.rem = ge ? 31'(r2 - {1'b0, p.mass}) : r2[30:0];
		r.dq = {p.dq[30:0], ge};
		return r;
	endfunction

endpackage

@@ design/vvs_front.sv @@
// Front end: input register that accepts and classifies items for the queue.
`timescale 1ns / 1ps

module vvs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  req_type,
	input  logic signed [31:0]    position,
	input  logic signed [31:0]    velocity,
	input  logic signed [31:0]    accel_old,
	input  logic signed [31:0]    force_req,
	input  logic [30:0]           mass,
	input  vvs_pkg::qstat_t       q_stat,
	output logic                  q_wr_en,
	output vvs_pkg::entry_t       q_wr_data
);

	logic            valid_q;
	vvs_pkg::entry_t item_q;
	logic            take;

	// The register holds while its item cannot enter the queue.
	assign full = valid_q && q_stat.full;
	assign take = push && !full;
	assign q_wr_en = valid_q && !q_stat.full;
	assign q_wr_data = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= take || (valid_q && q_stat.full);
		end
	end

	// Classify the beat: request kind, force sign and magnitude, zero mass.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q.kind <= req_type ? vvs_pkg::REQ_KICK : vvs_pkg::REQ_DRIFT;
			item_q.pos <= position;
			item_q.vel <= velocity;
			item_q.acc <= accel_old;
			item_q.force_neg <= force_req[31];
			item_q.force_mag <= force_req[31] ? 32'(-force_req) : 32'(force_req);
			item_q.mass <= mass;
			item_q.mass_zero <= (mass == '0);
		end
	end

endmodule

@@ design/vvs_queue.sv @@
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps

module vvs_queue #(
	parameter int DEPTH = vvs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  vvs_pkg::entry_t wr_data,
	input  logic            rd_en,
	output vvs_pkg::entry_t rd_data,
	output vvs_pkg::qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	vvs_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/vvs_back.sv @@
// Back end: pipelined drift arithmetic, restoring divider and kick arithmetic.
`timescale 1ns / 1ps

module vvs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vvs_pkg::DT_W-1:0]    time_step,
	input  vvs_pkg::entry_t             q_rd_data,
	input  vvs_pkg::qstat_t             q_stat,
	output logic                        q_rd_en,
	input  logic                        pop,
	output logic                        empty,
	output logic signed [31:0]          new_position,
	output logic signed [31:0]          new_velocity,
	output logic signed [31:0]          new_accel,
	output logic                        mass_zero,
	output logic                        saturated
);

	localparam int F = vvs_pkg::FRAC_BITS;
	localparam int N = vvs_pkg::DIV_STEPS;

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s38, v_s39;
	logic [N-1:0] div_v_s6;
	vvs_pkg::pipe_t pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s38, pipe_s39;
	vvs_pkg::pipe_t div_s6 [N];
	vvs_pkg::pipe_t nx1, nx2, nx3, nx4, nx5, nx38, nx39;

	logic                     out_valid_q;
	logic signed [31:0]       npos_q, nvel_q, nacc_q;
	logic                     mzero_q, sat_q;

	// Stage 1 signals.
	logic [31:0] amag;
	logic [62:0] prod_a;
	logic [30:0] rem0;
	// Stage 2 signals.
	logic [62:0]        hr;
	logic signed [63:0] hs, ws;
	logic [63:0]        wm;
	// Stage 3 signals.
	logic [vvs_pkg::WMAG_W-1:0] wmag;
	logic [62:0]                plo;
	logic [vvs_pkg::PHI_W-1:0]  phi;
	// Stage 4 signals.
	logic [vvs_pkg::SUM_W-1:0]  sum4, rs4;
	logic [vvs_pkg::RES_W-1:0]  res4;
	// Stage 5 signals.
	logic signed [63:0] dl5, d5, pv5;
	vvs_pkg::sat_t      st5;
	// Stage 38 signals.
	vvs_pkg::pipe_t     last;
	logic [31:0]        quo;
	logic signed [31:0] nacc;
	logic               asat;
	logic signed [63:0] ssum;
	logic [63:0]        smag;
	// Stage 39 and output signals.
	logic [62:0]        pk;
	logic [62:0]        pv;
	logic signed [63:0] vs;
	vvs_pkg::sat_t      st_out;

	// The whole pipeline moves unless a finished result waits unread.
	assign adv = !out_valid_q || pop;
	assign q_rd_en = adv && !q_stat.empty;
	assign empty = !out_valid_q;
	assign new_position = npos_q;
	assign new_velocity = nvel_q;
	assign new_accel = nacc_q;
	assign mass_zero = mzero_q;
	assign saturated = sat_q;

	// Stage 1: acceleration times dt, and divider setup from the force.
	always_comb begin
		amag = q_rd_data.acc[31] ? 32'(-q_rd_data.acc) : 32'(q_rd_data.acc);
		prod_a = amag * time_step;
		rem0 = 31'(q_rd_data.force_mag >> (32 - F));
		nx1.kind = q_rd_data.kind;
		nx1.pos = q_rd_data.pos;
		nx1.vel = q_rd_data.vel;
		nx1.acc = q_rd_data.acc;
		nx1.force_neg = q_rd_data.force_neg;
		nx1.mass = q_rd_data.mass;
		nx1.mass_zero = q_rd_data.mass_zero;
		nx1.sat = 1'b0;
		nx1.ovf = (rem0 >= q_rd_data.mass);
		nx1.rem = rem0;
		nx1.dq = 32'(q_rd_data.force_mag << F);
		nx1.neg = q_rd_data.acc[31];
		nx1.scr_a = prod_a;
		nx1.scr_b = '0;
	end

	// Stage 2: round the half-step term and add the velocity.
	always_comb begin
		hr = (pipe_s1.scr_a + (63'd1 << F)) >> (F + 1);
		hs = pipe_s1.neg ? -$signed({1'b0, hr}) : $signed({1'b0, hr});
		ws = hs + 64'(pipe_s1.vel);
		wm = ws[63] ? 64'(-ws) : 64'(ws);
		nx2 = pipe_s1;
		nx2.neg = ws[63];
		nx2.scr_a = wm[62:0];
	end

	// Stage 3: the wide product dt * |w| as two partial products.
	always_comb begin
		wmag = pipe_s2.scr_a[vvs_pkg::WMAG_W-1:0];
		plo = wmag[31:0] * time_step;
		phi = wmag[vvs_pkg::WMAG_W-1:32] * time_step;
		nx3 = pipe_s2;
		nx3.scr_a = plo;
		nx3.scr_b = phi;
	end

	// Stage 4: join the partial products, round and cap the magnitude.
	always_comb begin
		sum4 = (vvs_pkg::SUM_W'(pipe_s3.scr_b) << 32) + vvs_pkg::SUM_W'(pipe_s3.scr_a)
			+ (vvs_pkg::SUM_W'(1) << (F - 1));
		rs4 = sum4 >> F;
		res4 = (rs4 > vvs_pkg::SUM_W'(vvs_pkg::BIG_CAP)) ? vvs_pkg::BIG_CAP
			: rs4[vvs_pkg::RES_W-1:0];
		nx4 = pipe_s3;
		nx4.scr_a = 63'(res4);
	end

	// Stage 5: add to the position and clamp; only drift items use it.
	always_comb begin
		dl5 = $signed(64'(pipe_s4.scr_a[vvs_pkg::RES_W-1:0]));
		d5 = pipe_s4.neg ? -dl5 : dl5;
		pv5 = 64'(pipe_s4.pos) + d5;
		st5 = vvs_pkg::sat32(pv5);
		nx5 = pipe_s4;
		if (pipe_s4.kind == vvs_pkg::REQ_DRIFT) begin
			nx5.pos = st5.val;
			nx5.sat = st5.sat;
		end
	end

	// Stage 38: saturate the quotient into the new acceleration, sum accelerations.
	always_comb begin
		last = div_s6[N-1];
		quo = last.dq;
		nacc = '0;
		asat = 1'b0;
		if (!last.mass_zero) begin
			if (!last.force_neg) begin
				if (last.ovf || quo[31]) begin
					nacc = 32'sh7fff_ffff;
					asat = 1'b1;
				end else begin
					nacc = $signed(quo);
				end
			end else begin
				if (last.ovf || (quo > 32'h8000_0000)) begin
					nacc = 32'sh8000_0000;
					asat = 1'b1;
				end else begin
					nacc = $signed(32'(-quo));
				end
			end
		end
		ssum = 64'(last.acc) + 64'(nacc);
		smag = ssum[63] ? 64'(-ssum) : 64'(ssum);
		nx38 = last;
		nx38.neg = ssum[63];
		nx38.scr_a = smag[62:0];
		if (last.kind == vvs_pkg::REQ_KICK) begin
			nx38.acc = nacc;
			nx38.sat = asat;
		end
	end

	// Stage 39: dt times the summed accelerations.
	always_comb begin
		pk = pipe_s38.scr_a[32:0] * time_step;
		nx39 = pipe_s38;
		nx39.scr_a = pk;
	end

	// Output stage: round the half step, add the velocity and clamp.
	always_comb begin
		pv = (pipe_s39.scr_a + (63'd1 << F)) >> (F + 1);
		vs = 64'(pipe_s39.vel) + (pipe_s39.neg ? -$signed({1'b0, pv}) : $signed({1'b0, pv}));
		st_out = vvs_pkg::sat32(vs);
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			div_v_s6 <= '0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			div_v_s6 <= {div_v_s6[N-2:0], v_s5};
			v_s38 <= div_v_s6[N-1];
			v_s39 <= v_s38;
			out_valid_q <= v_s39;
		end
	end

	// Payload registers of the head and tail stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s1 <= nx1;
			pipe_s2 <= nx2;
			pipe_s3 <= nx3;
			pipe_s4 <= nx4;
			pipe_s5 <= nx5;
			pipe_s38 <= nx38;
			pipe_s39 <= nx39;
			if (pipe_s39.kind == vvs_pkg::REQ_KICK) begin
				npos_q <= '0;
				nvel_q <= st_out.val;
				nacc_q <= pipe_s39.acc;
				mzero_q <= pipe_s39.mass_zero;
				sat_q <= pipe_s39.sat || st_out.sat;
			end else begin
				npos_q <= pipe_s39.pos;
				nvel_q <= '0;
				nacc_q <= '0;
				mzero_q <= 1'b0;
				sat_q <= pipe_s39.sat;
			end
		end
	end

	// Divider: one restoring step per stage, one quotient bit each.
	for (genvar k = 0; k < N; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					div_s6[k] <= vvs_pkg::div_step(pipe_s5);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					div_s6[k] <= vvs_pkg::div_step(div_s6[k-1]);
				end
			end
		end
	end

endmodule

@@ design/velocity_verlet_step_top.sv @@
// Velocity Verlet step for one coordinate: top level with the dt register.
//
// Usage: items enter through push/full; a beat is taken when push is high and
// full is low. req_type 0 is a drift (position update), 1 is a kick (new
// acceleration from force over mass, then the velocity update). Each item gives
// one result, shown while empty is low and taken when pop is high.
// The time step is to be written through cfg_we/cfg_wdata only while the block
// is idle; the user must see to it, as the block does not enforce it. A beat
// passes the input register, the queue, five drift stages, 32 restoring divider
// stages (one quotient bit each), and three kick stages ending in the output
// register. Throughput: one item per cycle while results are popped; the divider
// and multipliers are fully pipelined, and the queue lets the front keep taking
// beats briefly. Reset clears all valid bits and the queue and sets the time step
// to 655. When the receiver stalls, the whole back pipeline holds, the queue
// fills, and full rises once the queue and the input register are occupied.
`timescale 1ns / 1ps

module velocity_verlet_step_top #(
	parameter int QUEUE_DEPTH = vvs_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     req_type,
	input  logic signed [31:0]       position,
	input  logic signed [31:0]       velocity,
	input  logic signed [31:0]       accel_old,
	input  logic signed [31:0]       force_req,
	input  logic [30:0]              mass,
	input  logic                     cfg_we,
	input  logic [vvs_pkg::DT_W-1:0] cfg_wdata,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [31:0]       new_position,
	output logic signed [31:0]       new_velocity,
	output logic signed [31:0]       new_accel,
	output logic                     mass_zero,
	output logic                     saturated
);

`include "velocity_verlet_step_top_assert.svh"

	logic [vvs_pkg::DT_W-1:0] time_step_q;
	logic                     q_wr_en;
	logic                     q_rd_en;
	vvs_pkg::entry_t          q_wr_data;
	vvs_pkg::entry_t          q_rd_data;
	vvs_pkg::qstat_t          q_stat;

	// Time step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= vvs_pkg::TIME_STEP_RST;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	vvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.position  (position),
		.velocity  (velocity),
		.accel_old (accel_old),
		.force_req (force_req),
		.mass      (mass),
		.q_stat    (q_stat),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	vvs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	vvs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_step    (time_step_q),
		.q_rd_data    (q_rd_data),
		.q_stat       (q_stat),
		.q_rd_en      (q_rd_en),
		.pop          (pop),
		.empty        (empty),
		.new_position (new_position),
		.new_velocity (new_velocity),
		.new_accel    (new_accel),
		.mass_zero    (mass_zero),
		.saturated    (saturated)
	);

	// A zero-mass kick reports no acceleration and no position.
	`VVS_ASSERT_NOW(a_mass_zero_clean, !empty && mass_zero, new_accel == '0 && new_position == '0, "zero-mass result carries acceleration or position")
	// A nonzero position only comes from a drift, which has no kick fields.
	`VVS_ASSERT_NOW(a_drift_exclusive, !empty && new_position != '0, new_velocity == '0 && new_accel == '0 && !mass_zero, "drift result carries kick fields")
	// The front never writes a full queue, and a written beat is there next cycle.
	`VVS_ASSERT_NOW(a_no_overfill, q_wr_en, !q_stat.full, "front wrote into a full queue")
	`VVS_ASSERT_NEXT(a_queue_holds, q_wr_en, !q_stat.empty, "queue empty after a write")

endmodule

@@ dv/velocity_verlet_step_top_test.sv @@
// Self-checking testbench for the velocity Verlet step top level.
`timescale 1ns / 1ps

module velocity_verlet_step_top_test;

	// Expected contents of one result beat.
	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic               mz;
		logic               sat;
	} verlet_res_t;

	// One directed stimulus row; typed rows carry their expected result.
	typedef struct {
		vvs_pkg::req_t      kind;
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
		logic signed [31:0] frc;
		logic [30:0]        m;
		bit                 typed;
		logic signed [31:0] e_pos;
		logic signed [31:0] e_vel;
		logic signed [31:0] e_acc;
		logic               e_mz;
		logic               e_sat;
	} stim_row_t;

	localparam int N_DIR = 14;
	localparam int N_RAND = 1400;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic req_type = 1'b0;
	logic signed [31:0] position = '0;
	logic signed [31:0] velocity = '0;
	logic signed [31:0] accel_old = '0;
	logic signed [31:0] force_req = '0;
	logic [30:0] mass = '0;
	logic cfg_we = 1'b0;
	logic [vvs_pkg::DT_W-1:0] cfg_wdata = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [31:0] new_position;
	logic signed [31:0] new_velocity;
	logic signed [31:0] new_accel;
	logic mass_zero;
	logic saturated;

	verlet_res_t pending_results[$];
	logic [vvs_pkg::DT_W-1:0] dt_model = vvs_pkg::TIME_STEP_RST;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int kicks_in = 0;
	int sat_seen = 0;

	velocity_verlet_step_top u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_type(req_type),
		.position(position), .velocity(velocity), .accel_old(accel_old),
		.force_req(force_req), .mass(mass), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.empty(empty), .pop(pop), .new_position(new_position),
		.new_velocity(new_velocity), .new_accel(new_accel), .mass_zero(mass_zero),
		.saturated(saturated)
	);

	always #5 clk = ~clk;

	// Magnitude of a signed 64-bit value.
	function automatic longint unsigned mag64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Clamp to the signed 32-bit range, noting any clamp.
	function automatic logic signed [31:0] clamp32(input longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// round(dt * s / 2^(F+1)), half away from zero.
	function automatic longint half_dt_scale(input logic [vvs_pkg::DT_W-1:0] dt,
			input longint s);
		longint unsigned p;
		p = mag64(s) * longint'(dt);
		p = (p + (64'd1 << vvs_pkg::FRAC_BITS)) >> (vvs_pkg::FRAC_BITS + 1);
		return (s < 0) ? -longint'(p) : longint'(p);
	endfunction

	// Expected result of one item under step size dt.
	function automatic verlet_res_t verlet_predict(input vvs_pkg::req_t kind,
			input logic signed [31:0] pos, input logic signed [31:0] vel,
			input logic signed [31:0] acc, input logic signed [31:0] frc,
			input logic [30:0] m, input logic [vvs_pkg::DT_W-1:0] dt);
		verlet_res_t r;
		longint w;
		longint d;
		longint nacc;
		logic [127:0] prod;
		longint unsigned qm;
		logic sat;
		sat = 1'b0;
		r.pos = '0;
		r.vel = '0;
		r.acc = '0;
		r.mz = 1'b0;
		if (kind == vvs_pkg::REQ_DRIFT) begin
			// Position advance from the half-kicked velocity, capped before the clamp.
			w = longint'(vel) + half_dt_scale(dt, longint'(acc));
			prod = 128'(mag64(w)) * 128'(dt);
			prod = (prod + (128'd1 << (vvs_pkg::FRAC_BITS - 1))) >> vvs_pkg::FRAC_BITS;
			if (prod > (128'd1 << 40))
				prod = 128'd1 << 40;
			d = longint'(prod[63:0]);
			if (w < 0)
				d = -d;
			r.pos = clamp32(longint'(pos) + d, sat);
		end else begin
			// New acceleration from force over mass, then the velocity update.
			if (m == 0) begin
				r.mz = 1'b1;
				nacc = 0;
			end else begin
				qm = (mag64(longint'(frc)) << vvs_pkg::FRAC_BITS) / longint'(m);
				if (qm > (64'd1 << 40))
					qm = 64'd1 << 40;
				nacc = clamp32((frc < 0) ? -longint'(qm) : longint'(qm), sat);
			end
			r.acc = nacc[31:0];
			r.vel = clamp32(longint'(vel) + half_dt_scale(dt, longint'(acc) + nacc), sat);
		end
		r.sat = sat;
		return r;
	endfunction

	// Random 32-bit value with a bias toward the extremes.
	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 600)) - 300);
			3: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	// Random mass: zero, tiny, unit-scale, maximum or anything.
	function automatic logic [30:0] pick_mass();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 31'h7fff_ffff;
			2: return 31'($urandom_range(1, 16));
			3: return 31'($urandom_range(16384, 262144));
			default: return 31'($urandom);
		endcase
	endfunction

	// Drive one item and hold it until the block takes the beat.
	task automatic send_item(input vvs_pkg::req_t kind, input logic signed [31:0] pos,
			input logic signed [31:0] vel, input logic signed [31:0] acc,
			input logic signed [31:0] frc, input logic [30:0] m,
			input bit typed, input verlet_res_t typed_res);
		push = 1'b1;
		req_type = kind;
		position = pos;
		velocity = vel;
		accel_old = acc;
		force_req = frc;
		mass = m;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		pending_results.push_back(typed ? typed_res :
			verlet_predict(kind, pos, vel, acc, frc, m, dt_model));
		beats_in++;
		if (kind == vvs_pkg::REQ_KICK)
			kicks_in++;
		@(negedge clk);
	endtask

	// Wait for every expected beat, then let the pipeline settle.
	task automatic drain();
		push = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the step size while the block is idle.
	task automatic write_step(input logic [vvs_pkg::DT_W-1:0] dt);
		cfg_we = 1'b1;
		cfg_wdata = dt;
		@(negedge clk);
		cfg_we = 1'b0;
		dt_model = dt;
	endtask

	// Receiver stall pattern: free-running, random, or periodic stalls.
	int pop_cyc = 0;
	always @(negedge clk) begin
		pop_cyc <= pop_cyc + 1;
		case ((pop_cyc >> 8) % 3)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			default: pop <= ((pop_cyc % 11) > 6);
		endcase
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		verlet_res_t e;
		if (arst_n && pop && !empty) begin
			beats_out++;
			if (saturated)
				sat_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat pos=%h vel=%h", $time,
					new_position, new_velocity);
			end else begin
				e = pending_results.pop_front();
				if (new_position !== e.pos) begin
					errors++;
					$display("%0t: new_position exp %h act %h", $time, e.pos, new_position);
				end
				if (new_velocity !== e.vel) begin
					errors++;
					$display("%0t: new_velocity exp %h act %h", $time, e.vel, new_velocity);
				end
				if (new_accel !== e.acc) begin
					errors++;
					$display("%0t: new_accel exp %h act %h", $time, e.acc, new_accel);
				end
				if (mass_zero !== e.mz) begin
					errors++;
					$display("%0t: mass_zero exp %b act %b", $time, e.mz, mass_zero);
				end
				if (saturated !== e.sat) begin
					errors++;
					$display("%0t: saturated exp %b act %b", $time, e.sat, saturated);
				end
			end
		end
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Main sequence.
	initial begin
		stim_row_t dir_tbl [N_DIR];
		logic [vvs_pkg::DT_W-1:0] dt_list [7];
		verlet_res_t tr;
		int per_phase;
		int burst;

		dir_tbl = '{
			'{vvs_pkg::REQ_DRIFT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_DRIFT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0,
				1, 32'sh7fffffff, 0, 0, 0, 1},
			'{vvs_pkg::REQ_DRIFT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0,
				1, 32'sh80000000, 0, 0, 0, 1},
			'{vvs_pkg::REQ_KICK, 0, 0, 0, 32'sh7fffffff, 0, 1, 0, 0, 0, 1, 0},
			'{vvs_pkg::REQ_KICK, 0, 0, 0, 65536, 65536, 1, 0, 328, 65536, 0, 0},
			'{vvs_pkg::REQ_KICK, 0, 0, 0, 32'sh7fffffff, 1, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_KICK, 0, 0, 0, 32'sh80000000, 1, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_KICK, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
				31'h7fffffff, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_KICK, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1,
				0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_KICK, -1, -5, -200, -65536, 1, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_KICK, 7, 100, 3, 1, 31'h7fffffff, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_DRIFT, 32'sh80000000, -1, -1, 5, 5, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_DRIFT, 12345, 65536, 200, 0, 0, 0, 0, 0, 0, 0, 0},
			'{vvs_pkg::REQ_DRIFT, -12345, -65536, -200, -1, 3, 0, 0, 0, 0, 0, 0}
		};
		dt_list = '{31'd0, 31'h7fff_ffff, 31'd1, 31'd65536, 31'd655, 31'd3277, 31'd0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows at the reset step size.
		for (int i = 0; i < N_DIR; i++) begin
			tr = '{dir_tbl[i].e_pos, dir_tbl[i].e_vel, dir_tbl[i].e_acc,
				dir_tbl[i].e_mz, dir_tbl[i].e_sat};
			send_item(dir_tbl[i].kind, dir_tbl[i].pos, dir_tbl[i].vel, dir_tbl[i].acc,
				dir_tbl[i].frc, dir_tbl[i].m, dir_tbl[i].typed, tr);
		end
		drain();

		// Random phases, one step size each; the last one is random.
		per_phase = N_RAND / 8;
		for (int ph = 0; ph < 8; ph++) begin
			write_step((ph < 7) ? dt_list[ph] : 31'($urandom_range(1, 200000)));
			for (int n = 0; n < per_phase; ) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && n < per_phase; b++, n++) begin
					send_item(vvs_pkg::req_t'($urandom_range(0, 1)), pick32(), pick32(),
						pick32(), pick32(), pick_mass(), 0, tr);
					// Hold off mid-phase until every outstanding result is back.
					if (n == per_phase / 2)
						drain();
				end
				push = 1'b0;
				if ($urandom_range(0, 3) != 0)
					repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			drain();
		end

		$display("Sent %0d items (%0d kicks) over 9 step sizes; %0d results checked.",
			beats_in, kicks_in, beats_out);
		$display("Results that saturated: %0d; mismatches: %0d.", sat_seen, errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ velocity_verlet_step_top.f @@
+incdir+design
design/vvs_pkg.sv
design/vvs_front.sv
design/vvs_queue.sv
design/vvs_back.sv
design/velocity_verlet_step_top.sv
dv/velocity_verlet_step_top_test.sv
